// ===== sv/spbd_pkg.sv =====
// shared types, codes and reset values of the solenoid pulse buzz driver
package spbd_pkg;

    // default channel count and widths fixed by the item and register fields
    localparam int CHANNELS_DEF = 4;
    localparam int IDX_W        = 3;   // holds any channel index up to eight channels
    localparam int FUNC_W       = 3;
    localparam int CFG_IDX_W    = 3;
    localparam int CFG_DATA_W   = 8;
    localparam int TICK_W       = 9;

    typedef logic [IDX_W-1:0] t_idx;

    // item function codes
    localparam logic [FUNC_W-1:0] FN_TICK     = 3'd0;
    localparam logic [FUNC_W-1:0] FN_FIRE_ANY = 3'd1;
    localparam logic [FUNC_W-1:0] FN_FIRE_IDX = 3'd2;
    localparam logic [FUNC_W-1:0] FN_STOP     = 3'd3;
    localparam logic [FUNC_W-1:0] FN_SHUTDOWN = 3'd4;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_BUZZ_EN   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DWELL     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ON_TICKS  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_OFF_TICKS = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_PICK_MODE = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_ACT_LVL   = 3'd5;

    // register reset values
    localparam logic       RST_BUZZ_EN   = 1'b0;
    localparam logic [7:0] RST_DWELL     = 8'd12;
    localparam logic [7:0] RST_ON_TICKS  = 8'd4;
    localparam logic [7:0] RST_OFF_TICKS = 8'd4;
    localparam logic       RST_PICK_MODE = 1'b0;
    localparam logic [3:0] RST_ACT_LVL   = 4'hF;

    typedef struct packed {
        logic       buzz_en;
        logic [7:0] dwell;
        logic [7:0] on_ticks;
        logic [7:0] off_ticks;
        logic       pick_mode;
    } t_cfg;

    // command token walking down the row of channel cells
    typedef struct packed {
        logic              valid;
        logic [FUNC_W-1:0] func;
        t_idx              tgt;
        logic              tgt_ok;
        logic              idle_only;
        logic              claimed;
    } t_tok;

endpackage

// ===== sv/spbd_cell.sv =====
// one channel cell: click cycle state of a single solenoid, passes the token on
module spbd_cell #(
    parameter int   IDX     = 0,
    parameter logic RST_PIN = 1'b0
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  spbd_pkg::t_cfg    i_cfg,
    input  logic              i_level,
    input  spbd_pkg::t_tok    i_tok,
    output spbd_pkg::t_tok    o_tok,
    output logic              o_pin,
    output logic              o_busy
);

    localparam spbd_pkg::t_idx MY_IDX = spbd_pkg::t_idx'(IDX);
    localparam int TW = spbd_pkg::TICK_W;

    logic          r_run, n_run;
    logic          r_energ, n_energ;
    logic          r_pin, n_pin;
    logic [TW-1:0] r_el, n_el;
    logic [TW-1:0] r_ph, n_ph;
    logic          r_tok_v;
    spbd_pkg::t_tok r_tok, n_tok;

    logic [TW-1:0] w_period;
    logic [TW-1:0] w_el_inc;
    logic [TW-1:0] w_ph_inc;
    logic          w_hit;
    logic          w_refuse;

    assign w_period = {1'b0, i_cfg.on_ticks} + {1'b0, i_cfg.off_ticks};
    assign w_el_inc = (r_el != {TW{1'b1}}) ? r_el + TW'(1) : r_el;
    assign w_ph_inc = ((r_ph + TW'(1)) >= w_period) ? '0 : r_ph + TW'(1);
    assign w_hit    = i_tok.tgt_ok && (i_tok.tgt == MY_IDX);
    // refire rule: running blocks in plain mode, energized blocks in buzz mode
    assign w_refuse = i_cfg.buzz_en ? r_energ : r_run;

    always_comb begin
        n_run   = r_run;
        n_energ = r_energ;
        n_pin   = r_pin;
        n_el    = r_el;
        n_ph    = r_ph;
        n_tok   = i_tok;
        if (i_tok.valid) begin
            unique case (i_tok.func)
                spbd_pkg::FN_TICK: begin
                    if (r_run) begin
                        n_el = w_el_inc;
                        n_ph = w_ph_inc;
                        if (w_el_inc > {1'b0, i_cfg.dwell}) begin
                            n_pin   = ~i_level;
                            n_run   = 1'b0;
                            n_energ = 1'b0;
                        end else if (i_cfg.buzz_en) begin
                            if (w_ph_inc < {1'b0, i_cfg.on_ticks}) begin
                                if (!r_energ) begin
                                    n_energ = 1'b1;
                                    n_pin   = i_level;
                                end
                            end else if (r_energ) begin
                                n_energ = 1'b0;
                                n_pin   = ~i_level;
                            end
                        end
                    end
                end
                spbd_pkg::FN_FIRE_ANY: begin
                    if (!i_cfg.pick_mode) begin
                        if (w_hit && (!r_run || !i_tok.idle_only) && !w_refuse) begin
                            n_run   = 1'b1;
                            n_energ = 1'b1;
                            n_el    = '0;
                            n_ph    = '0;
                            n_pin   = i_level;
                        end
                    end else if (!i_tok.claimed && !r_run) begin
                        n_tok.claimed = 1'b1;
                        if (!w_refuse) begin
                            n_run   = 1'b1;
                            n_energ = 1'b1;
                            n_el    = '0;
                            n_ph    = '0;
                            n_pin   = i_level;
                        end
                    end
                end
                spbd_pkg::FN_FIRE_IDX: begin
                    if (w_hit && !w_refuse) begin
                        n_run   = 1'b1;
                        n_energ = 1'b1;
                        n_el    = '0;
                        n_ph    = '0;
                        n_pin   = i_level;
                    end
                end
                spbd_pkg::FN_STOP: begin
                    if (w_hit) begin
                        n_pin   = ~i_level;
                        n_run   = 1'b0;
                        n_energ = 1'b0;
                    end
                end
                spbd_pkg::FN_SHUTDOWN: begin
                    n_pin = ~i_level;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run   <= 1'b0;
            r_energ <= 1'b0;
            r_pin   <= RST_PIN;
            r_el    <= '0;
            r_ph    <= '0;
            r_tok_v <= 1'b0;
        end else begin
            r_run   <= n_run;
            r_energ <= n_energ;
            r_pin   <= n_pin;
            r_el    <= n_el;
            r_ph    <= n_ph;
            r_tok_v <= i_tok.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_tok <= n_tok;
    end

    always_comb begin
        o_tok       = r_tok;
        o_tok.valid = r_tok_v;
    end

    assign o_pin  = r_pin;
    assign o_busy = r_run;

endmodule

// ===== sv/solenoid_pulse_buzz_driver_unit.sv =====
// top level of the multi-channel solenoid pulse and buzz driver
//
// usage
//   input channel (i_valid / o_ready) takes one item: a function code, a
//   channel number and a random value. codes: tick, fire any idle channel,
//   fire given channel, stop given channel, shutdown.
//   output channel (o_valid / i_ready) returns one item per input item: the
//   drive level of every pin and the busy mask, sampled after the update.
//   the register port (i_cfg_we, i_cfg_idx, i_cfg_data) writes the addressed register.
// timing
//   an accepted item passes the pick stage (random channel number), then a
//   command token walks the row of channel cells, one cell per cycle. the
//   result is loaded into the output register once the token has left the
//   last cell and the register is free; only then is the next item taken,
//   so no new item enters before the last one is through; the walk sets the item rate.
// reset
//   synchronous, active low: all channels idle, pins inactive, registers at
//   their defaults, no result pending.
// stall
//   the result sits in an output register; a new item is still taken while
//   it waits. a finished walk holds until that register is free.
module solenoid_pulse_buzz_driver_unit #(
    parameter int CHANNELS = spbd_pkg::CHANNELS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // input items
    input  logic                                i_valid,
    output logic                                o_ready,
    input  logic [spbd_pkg::FUNC_W-1:0]         i_func,
    input  logic [1:0]                          i_channel,
    input  logic [7:0]                          i_random_pick,
    // result items
    output logic                                o_valid,
    input  logic                                i_ready,
    output logic [3:0]                          o_pin_levels,
    output logic [3:0]                          o_busy_mask,
    // register writes
    input  logic                                i_cfg_we,
    input  logic [spbd_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [spbd_pkg::CFG_DATA_W-1:0]     i_cfg_data
);

    // reciprocal for value modulo CHANNELS: q = (value * RECIP) >> 16 is exact
    // for 8-bit values and up to eight channels
    localparam int          RECIP_I = (65536 + CHANNELS - 1) / CHANNELS;
    localparam logic [16:0] RECIP   = 17'(RECIP_I);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_PICK = 2'd1;
    localparam logic [1:0] ST_WALK = 2'd2;
    localparam logic [1:0] ST_HOLD = 2'd3;

    logic [1:0] r_state, n_state;

    // configuration registers
    spbd_pkg::t_cfg r_cfg;
    logic [3:0]     r_act_lvl;

    // captured item
    logic [spbd_pkg::FUNC_W-1:0] r_func;
    logic [1:0]                  r_chan;
    logic [7:0]                  r_rnd;
    logic [7:0]                  r_q;

    logic [24:0] w_prod;
    logic [10:0] w_mul;
    logic [10:0] w_rem;

    // token injected into cell zero
    logic           r_inj_v;
    spbd_pkg::t_tok r_inj;
    spbd_pkg::t_tok w_tok [CHANNELS+1];

    logic [CHANNELS-1:0] w_level;
    logic [CHANNELS-1:0] w_pin;
    logic [CHANNELS-1:0] w_busy;
    logic [CHANNELS:0]   w_tok_v;

    // output register
    logic       r_out_v;
    logic [3:0] r_pins;
    logic [3:0] r_busy;
    logic [3:0] w_pins;
    logic [3:0] w_busym;
    logic       w_accept;
    logic       w_out_free;
    logic       w_load;
    logic       w_last_v;

    assign w_accept   = i_valid && o_ready;
    assign o_ready    = (r_state == ST_IDLE);
    assign w_out_free = !r_out_v || i_ready;
    assign w_last_v   = w_tok[CHANNELS].valid;
    assign w_load     = ((r_state == ST_WALK && w_last_v) || r_state == ST_HOLD) && w_out_free;

    // first step of the modulo: the quotient, registered before the back multiply
    assign w_prod = 25'(i_random_pick) * 25'(RECIP);
    assign w_mul  = 11'(r_q) * 11'(CHANNELS);
    assign w_rem  = 11'(r_rnd) - w_mul;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.buzz_en   <= spbd_pkg::RST_BUZZ_EN;
            r_cfg.dwell     <= spbd_pkg::RST_DWELL;
            r_cfg.on_ticks  <= spbd_pkg::RST_ON_TICKS;
            r_cfg.off_ticks <= spbd_pkg::RST_OFF_TICKS;
            r_cfg.pick_mode <= spbd_pkg::RST_PICK_MODE;
            r_act_lvl       <= spbd_pkg::RST_ACT_LVL;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                spbd_pkg::REG_BUZZ_EN:   r_cfg.buzz_en   <= i_cfg_data[0];
                spbd_pkg::REG_DWELL:     r_cfg.dwell     <= i_cfg_data;
                spbd_pkg::REG_ON_TICKS:  r_cfg.on_ticks  <= i_cfg_data;
                spbd_pkg::REG_OFF_TICKS: r_cfg.off_ticks <= i_cfg_data;
                spbd_pkg::REG_PICK_MODE: r_cfg.pick_mode <= i_cfg_data[0];
                spbd_pkg::REG_ACT_LVL:   r_act_lvl       <= i_cfg_data[3:0];
                default: begin
                end
            endcase
        end
    end

    // sequencer: idle -> pick -> walk (-> hold while the output is full)
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: if (w_accept) n_state = ST_PICK;
            ST_PICK: n_state = ST_WALK;
            ST_WALK: begin
                if (w_last_v) n_state = w_out_free ? ST_IDLE : ST_HOLD;
            end
            ST_HOLD: if (w_out_free) n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_inj_v <= 1'b0;
            r_out_v <= 1'b0;
        end else begin
            r_state <= n_state;
            r_inj_v <= (r_state == ST_PICK);
            if (w_load) begin
                r_out_v <= 1'b1;
            end else if (i_ready) begin
                r_out_v <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_func <= i_func;
            r_chan <= i_channel;
            r_rnd  <= i_random_pick;
            r_q    <= w_prod[23:16];
        end
        if (r_state == ST_PICK) begin
            // the valid flag of the injected token comes from r_inj_v
            r_inj.valid     <= 1'b1;
            r_inj.func      <= r_func;
            // random pick targets value modulo CHANNELS, the others the given channel
            r_inj.tgt       <= (r_func == spbd_pkg::FN_FIRE_ANY)
                               ? spbd_pkg::t_idx'(w_rem) : spbd_pkg::t_idx'(r_chan);
            r_inj.tgt_ok    <= (r_func == spbd_pkg::FN_FIRE_ANY)
                               || (4'(r_chan) < 4'(CHANNELS));
            // with a single channel a random pick (pick mode 0) skips the idle check; the refire rule still applies
            r_inj.idle_only <= (CHANNELS > 1);
            r_inj.claimed   <= 1'b0;
        end
        if (w_load) begin
            r_pins <= w_pins;
            r_busy <= w_busym;
        end
    end

    always_comb begin
        w_tok[0]       = r_inj;
        w_tok[0].valid = r_inj_v;
    end

    // row of channel cells, token handed from cell to cell each cycle
    for (genvar g = 0; g < CHANNELS; g++) begin : g_cell
        if (g < 4) begin : g_lvl
            assign w_level[g] = r_act_lvl[g];
        end else begin : g_lvl_hi
            // channels above the fourth are active high
            assign w_level[g] = 1'b1;
        end

        spbd_cell #(
            .IDX     (g),
            .RST_PIN ((g < 4) ? ~spbd_pkg::RST_ACT_LVL[g % 4] : 1'b0)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_cfg   (r_cfg),
            .i_level (w_level[g]),
            .i_tok   (w_tok[g]),
            .o_tok   (w_tok[g+1]),
            .o_pin   (w_pin[g]),
            .o_busy  (w_busy[g])
        );
    end

    for (genvar g = 0; g <= CHANNELS; g++) begin : g_tv
        assign w_tok_v[g] = w_tok[g].valid;
    end

    // only the first four channels are visible at the outputs
    for (genvar g = 0; g < 4; g++) begin : g_out
        if (g < CHANNELS) begin : g_used
            assign w_pins[g]  = w_pin[g];
            assign w_busym[g] = w_busy[g];
        end else begin : g_unused
            assign w_pins[g]  = 1'b0;
            assign w_busym[g] = 1'b0;
        end
    end

    assign o_valid      = r_out_v;
    assign o_pin_levels = r_pins;
    assign o_busy_mask  = r_busy;

`ifndef SYNTHESIS
    // at most one command token is ever in the cell row
    a_one_token: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones(w_tok_v) <= 1)
        else $error("more than one token in the cell row");

    // no token is in flight while a new item can be taken
    a_idle_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_ready |-> (w_tok_v == '0))
        else $error("token in flight while taking a new item");

    // a token leaving the last cell with room at the output yields a result
    a_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_WALK && w_last_v && w_out_free) |=> o_valid)
        else $error("finished walk did not produce a result");

    // an accepted item always enters the row after the pick stage
    a_inject: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> ##1 r_inj_v)
        else $error("token not injected after item accept");
`endif

endmodule
